>>> rtl/tea_block_cipher_core_assert.svh
// Assertion macros for the TEA block cipher core.
`ifndef TEA_BLOCK_CIPHER_CORE_ASSERT_SVH
`define TEA_BLOCK_CIPHER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tbc_pkg.sv
// Shared types and constants for the TEA block cipher core.
package tbc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [WordW-1:0] TeaDelta = 32'h9e37_79b9;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_WORD0 = 8'd0,
    CFG_KEY_WORD1 = 8'd1,
    CFG_KEY_WORD2 = 8'd2,
    CFG_KEY_WORD3 = 8'd3
  } tbc_cfg_idx_e;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } tbc_op_e;

  typedef struct packed {
    logic             operation;
    logic [WordW-1:0] block_left;
    logic [WordW-1:0] block_right;
  } tbc_in_t;

  typedef struct packed {
    logic [WordW-1:0] out_left;
    logic [WordW-1:0] out_right;
  } tbc_out_t;

  typedef struct packed {
    logic [WordW-1:0] w3;
    logic [WordW-1:0] w2;
    logic [WordW-1:0] w1;
    logic [WordW-1:0] w0;
  } tbc_key_t;

endpackage

>>> rtl/tea_block_cipher_core.sv
// Top level of the pipelined TEA block cipher core.

// TEA encrypt/decrypt of one 64-bit block per transaction under a 128-bit key held in
// four configuration registers (index 0..3 = key words 0..3, writes to other indices are
// dropped; write keys only while no block is in flight). The datapath is a chain of
// 2*CYCLES register stages, each one half of a TEA cycle (one word update), so a block
// may be accepted on every clock that the chain is not held, ending in the registered
// output. The per-stage sum is a constant worked out at elaboration for both directions,
// and the operation bit travels with each block, so encrypt and decrypt transactions mix
// freely. A two-entry output (output register plus skid register) keeps in_ready_o a
// registered signal: the chain advances whenever the skid register is empty.
`include "tea_block_cipher_core_assert.svh"

module tea_block_cipher_core import tbc_pkg::*; #(
  parameter int unsigned CYCLES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tbc_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tbc_out_t           out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i
);

  localparam int unsigned Stages = 2 * CYCLES;

  tbc_key_t key_q, key_d;

  logic    stg_valid [Stages+1];
  tbc_in_t stg_data  [Stages+1];
  logic    en;

  logic     out_valid_q, out_valid_d;
  tbc_out_t out_q, out_d;
  logic     skid_valid_q, skid_valid_d;
  tbc_out_t skid_q, skid_d;
  tbc_out_t last_res;
  logic     out_free;

  // Key registers: always ready, unknown indices fall through untouched.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    key_d = key_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEY_WORD0: key_d.w0 = cfg_data_i;
        CFG_KEY_WORD1: key_d.w1 = cfg_data_i;
        CFG_KEY_WORD2: key_d.w2 = cfg_data_i;
        CFG_KEY_WORD3: key_d.w3 = cfg_data_i;
        default:       key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  // Advance the whole chain together; hold it while the skid register is occupied.
  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  assign stg_valid[0] = in_valid_i;
  assign stg_data[0]  = in_data_i;

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    localparam int unsigned    Round   = s / 2;
    localparam logic [63:0]    EncProd = 64'(Round + 1) * 64'(TeaDelta);
    localparam logic [63:0]    DecProd = 64'(CYCLES - Round) * 64'(TeaDelta);
    localparam logic [WordW-1:0] EncSum = EncProd[WordW-1:0];
    localparam logic [WordW-1:0] DecSum = DecProd[WordW-1:0];
    localparam logic           Second  = 1'((s % 2) == 1);

    tbc_stage #(
      .EncSum     (EncSum),
      .DecSum     (DecSum),
      .SecondHalf (Second)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (stg_valid[s]),
      .data_i  (stg_data[s]),
      .key_i   (key_q),
      .valid_o (stg_valid[s+1]),
      .data_o  (stg_data[s+1])
    );
  end

  assign last_res.out_left  = stg_data[Stages].block_left;
  assign last_res.out_right = stg_data[Stages].block_right;

  // Output register with skid: a stalled result parks in the skid register.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = stg_valid[Stages];
        out_d       = last_res;
      end
    end else if (en && stg_valid[Stages]) begin
      skid_valid_d = 1'b1;
      skid_d       = last_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The skid register is only ever filled behind a waiting result.
  `TBC_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full with empty output")
  // An accepted transaction lands in the first stage.
  `TBC_ASSERT_NEXT(a_accept_enters, in_valid_i && in_ready_o, stg_valid[1], "accepted block lost")
  // A drained output empties the skid register on the next cycle.
  `TBC_ASSERT_NEXT(a_skid_drains, skid_valid_q && out_ready_i, !skid_valid_q, "skid not drained")

endmodule

>>> rtl/tbc_stage.sv
// One registered half-cycle of TEA: updates one word of the block.
module tbc_stage import tbc_pkg::*; #(
  parameter logic [WordW-1:0] EncSum     = 32'h9e37_79b9,
  parameter logic [WordW-1:0] DecSum     = 32'h9e37_79b9,
  parameter logic             SecondHalf = 1'b0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  tbc_in_t  data_i,
  input  tbc_key_t key_i,
  output logic     valid_o,
  output tbc_in_t  data_o
);

  logic             valid_q;
  tbc_in_t          data_q, data_d;
  logic             upd_left;
  logic [WordW-1:0] src, dst, ka, kb, sum, mix, res;

  // Encrypt updates left then right; decrypt undoes right then left.
  always_comb begin
    upd_left = (data_i.operation == SecondHalf);
    src      = upd_left ? data_i.block_right : data_i.block_left;
    dst      = upd_left ? data_i.block_left  : data_i.block_right;
    ka       = upd_left ? key_i.w0 : key_i.w2;
    kb       = upd_left ? key_i.w1 : key_i.w3;
    sum      = (data_i.operation == OP_DECRYPT) ? DecSum : EncSum;
    mix      = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
    res      = (data_i.operation == OP_DECRYPT) ? (dst - mix) : (dst + mix);
    data_d   = data_i;
    if (upd_left) begin
      data_d.block_left = res;
    end else begin
      data_d.block_right = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
